### rtl/llqm_pkg.sv
// Shared types and constants for the linked-list queue manager.
`timescale 1ns / 1ps

package llqm_pkg;

  localparam int unsigned NODE_W   = 4;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned ID_SPACE = 1 << NODE_W;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT  = 3'd0,
    REQ_PUSH_BACK   = 3'd1,
    REQ_POP         = 3'd2,
    REQ_GET_AT      = 3'd3,
    REQ_REMOVE_AT   = 3'd4,
    REQ_REMOVE_NODE = 3'd5,
    REQ_INDEX_OF    = 3'd6,
    REQ_NEXT_OF     = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_e;

  // One queue slot held by a cell.
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
  } slot_t;

  // Probe that travels down the row, one cell per cycle.
  typedef struct packed {
    logic              valid;
    req_e              req;
    logic [NODE_W-1:0] key;
    logic [POS_W-1:0]  pos;
    logic              found;
    logic              nxt;
    logic [NODE_W-1:0] node;
    logic [POS_W-1:0]  idx;
  } tok_t;

  // Broadcast shift command: insert or delete at one position.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [NODE_W-1:0] node;
  } upd_t;

endpackage

### rtl/llqm_if.sv
// Request and response channel interfaces of the linked-list queue manager.
`timescale 1ns / 1ps

interface llqm_req_if;
  logic                        valid;
  logic                        ready;
  llqm_pkg::req_e              req_type;
  logic [llqm_pkg::NODE_W-1:0] node_id;
  logic [llqm_pkg::POS_W-1:0]  position;

  modport source (output valid, output req_type, output node_id, output position,
                  input ready);
  modport sink   (input valid, input req_type, input node_id, input position,
                  output ready);
endinterface

interface llqm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [llqm_pkg::NODE_W-1:0] node_out;
  logic [llqm_pkg::POS_W-1:0]  index_out;
  logic [llqm_pkg::LEN_W-1:0]  count;

  modport source (output valid, output ok, output node_out, output index_out,
                  output count, input ready);
  modport sink   (input valid, input ok, input node_out, input index_out,
                  input count, output ready);
endinterface

### rtl/linked_list_queue_manager.sv
// Top level of the linked-list queue manager: cell row and request control.
`timescale 1ns / 1ps

// The queue is held in order in a row of min(NODES, 16) cells, position 0 at
// the front; a node id can be queued at most once, so at most 16 slots ever
// fill. Each request launches a probe into cell 0 that moves one cell per
// cycle and collects the answer (hit, node, position, duplicate check) as it
// passes; once it leaves the last cell, one broadcast shift inserts or deletes
// a slot and the response is loaded into the output register. A new request is
// accepted only once the last one has finished, its pace set by the probe's
// trip through the cell row. The response register can hold a result
// while the next request is accepted; a request finishes only once that
// register is free. Nodes with id NODES or more are never queued.
module linked_list_queue_manager #(
  parameter int unsigned NODES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  llqm_req_if.sink          req_i,
  llqm_rsp_if.source        rsp_o
);

  localparam int unsigned CELLS = (NODES < llqm_pkg::ID_SPACE) ? NODES : llqm_pkg::ID_SPACE;

  llqm_pkg::state_e            state_q, state_d;
  llqm_pkg::tok_t              res_q;
  logic [llqm_pkg::LEN_W-1:0]  len_q, len_d;
  logic                        out_valid_q;
  logic                        out_ok_q;
  logic [llqm_pkg::NODE_W-1:0] out_node_q;
  logic [llqm_pkg::POS_W-1:0]  out_idx_q;

  llqm_pkg::tok_t  launch_tok;
  llqm_pkg::tok_t  toks   [CELLS];
  llqm_pkg::slot_t slots  [CELLS];
  llqm_pkg::upd_t  upd;
  logic            accept;
  logic            finish;
  logic            out_free;
  logic            key_ok;
  logic            ok_d;
  logic [llqm_pkg::NODE_W-1:0] node_out_d;
  logic [llqm_pkg::POS_W-1:0]  idx_out_d;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign key_ok   = (32'(res_q.key) < NODES);

  // Launch the probe into cell 0 on the accepting edge.
  always_comb begin
    launch_tok       = '0;
    launch_tok.valid = accept;
    launch_tok.req   = req_i.req_type;
    launch_tok.key   = req_i.node_id;
    launch_tok.pos   = req_i.position;
  end

  // Cell row: probe flows toward the back, slots shift either way.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    llqm_pkg::tok_t  tok_in;
    llqm_pkg::slot_t left;
    llqm_pkg::slot_t right;

    if (k == 0) begin : g_first
      assign tok_in = launch_tok;
      assign left   = '0;
    end else begin : g_inner
      assign tok_in = toks[k-1];
      assign left   = slots[k-1];
    end

    if (k == CELLS - 1) begin : g_last
      assign right = '0;
    end else begin : g_body
      assign right = slots[k+1];
    end

    llqm_cell #(
      .POS(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_in),
      .tok_o  (toks[k]),
      .upd_i  (upd),
      .left_i (left),
      .right_i(right),
      .slot_o (slots[k])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      llqm_pkg::ST_IDLE:  if (accept) state_d = llqm_pkg::ST_SWEEP;
      llqm_pkg::ST_SWEEP: if (toks[CELLS-1].valid) state_d = llqm_pkg::ST_DONE;
      llqm_pkg::ST_DONE:  if (out_free) state_d = llqm_pkg::ST_IDLE;
      default:            state_d = llqm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the control: ready, finish, and the result / shift decision.
  always_comb begin
    req_i.ready = (state_q == llqm_pkg::ST_IDLE);
    finish      = (state_q == llqm_pkg::ST_DONE) && out_free;
    ok_d        = 1'b0;
    node_out_d  = '0;
    idx_out_d   = '0;
    upd         = '0;
    upd.node    = res_q.key;
    case (res_q.req)
      llqm_pkg::REQ_PUSH_FRONT: begin
        ok_d    = key_ok && !res_q.found;
        upd.ins = ok_d;
      end
      llqm_pkg::REQ_PUSH_BACK: begin
        ok_d    = key_ok && !res_q.found;
        upd.ins = ok_d;
        upd.pos = len_q[llqm_pkg::POS_W-1:0];
      end
      llqm_pkg::REQ_POP, llqm_pkg::REQ_REMOVE_AT: begin
        ok_d       = res_q.found;
        node_out_d = res_q.found ? res_q.node : '0;
        upd.del    = res_q.found;
        upd.pos    = (res_q.req == llqm_pkg::REQ_POP) ? '0 : res_q.pos;
      end
      llqm_pkg::REQ_GET_AT, llqm_pkg::REQ_NEXT_OF: begin
        ok_d       = res_q.found;
        node_out_d = res_q.found ? res_q.node : '0;
      end
      llqm_pkg::REQ_REMOVE_NODE: begin
        ok_d    = res_q.found;
        upd.del = res_q.found;
        upd.pos = res_q.idx;
      end
      llqm_pkg::REQ_INDEX_OF: begin
        ok_d      = res_q.found;
        idx_out_d = res_q.found ? res_q.idx : '0;
      end
      default: ok_d = 1'b0;
    endcase
    // Hold the row until the response register can take the result.
    if (!finish) upd = '0;
  end

  always_comb begin
    len_d = len_q;
    if (upd.ins) len_d = len_q + llqm_pkg::LEN_W'(1);
    else if (upd.del) len_d = len_q - llqm_pkg::LEN_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= llqm_pkg::ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      if (finish) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Payload registers: capture the probe at the row exit, load the response.
  always_ff @(posedge clk_i) begin
    if (state_q == llqm_pkg::ST_SWEEP && toks[CELLS-1].valid) res_q <= toks[CELLS-1];
    if (finish) begin
      out_ok_q   <= ok_d;
      out_node_q <= node_out_d;
      out_idx_q  <= idx_out_d;
    end
  end

  // Count follows the next value of the length register, which already reflects the request.
  logic [llqm_pkg::LEN_W-1:0] out_cnt_q;
  always_ff @(posedge clk_i) begin
    if (finish) out_cnt_q <= len_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.ok        = out_ok_q;
  assign rsp_o.node_out  = out_node_q;
  assign rsp_o.index_out = out_idx_q;
  assign rsp_o.count     = out_cnt_q;

endmodule

### rtl/llqm_cell.sv
// One queue cell: holds the slot at a fixed position and evaluates the passing probe.
`timescale 1ns / 1ps

module llqm_cell #(
  parameter int unsigned POS = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  llqm_pkg::tok_t  tok_i,
  output llqm_pkg::tok_t  tok_o,
  input  llqm_pkg::upd_t  upd_i,
  input  llqm_pkg::slot_t left_i,
  input  llqm_pkg::slot_t right_i,
  output llqm_pkg::slot_t slot_o
);

  logic                        valid_q, valid_d;
  logic [llqm_pkg::NODE_W-1:0] node_q, node_d;
  llqm_pkg::tok_t              tok_q, tok_d;
  logic                        match;
  logic                        at_pos;
  logic                        at_upd;
  logic                        above_upd;

  assign match     = valid_q && (node_q == tok_i.key);
  assign at_pos    = (32'(tok_i.pos) == POS);
  assign at_upd    = (32'(upd_i.pos) == POS);
  assign above_upd = (POS > 32'(upd_i.pos));

  // Probe evaluation against this cell's slot.
  always_comb begin
    tok_d     = tok_i;
    tok_d.nxt = 1'b0;
    case (tok_i.req)
      llqm_pkg::REQ_PUSH_FRONT, llqm_pkg::REQ_PUSH_BACK: begin
        if (match) tok_d.found = 1'b1;
      end
      llqm_pkg::REQ_POP: begin
        if (POS == 0 && valid_q) begin
          tok_d.found = 1'b1;
          tok_d.node  = node_q;
        end
      end
      llqm_pkg::REQ_GET_AT, llqm_pkg::REQ_REMOVE_AT: begin
        if (at_pos && valid_q) begin
          tok_d.found = 1'b1;
          tok_d.node  = node_q;
        end
      end
      llqm_pkg::REQ_REMOVE_NODE, llqm_pkg::REQ_INDEX_OF: begin
        if (match) begin
          tok_d.found = 1'b1;
          tok_d.idx   = llqm_pkg::POS_W'(POS);
        end
      end
      llqm_pkg::REQ_NEXT_OF: begin
        if (tok_i.nxt && valid_q) begin
          tok_d.found = 1'b1;
          tok_d.node  = node_q;
        end
        tok_d.nxt = match;
      end
      default: tok_d = tok_i;
    endcase
  end

  // Shift update: open a gap on insert, close it on delete.
  always_comb begin
    valid_d = valid_q;
    node_d  = node_q;
    if (upd_i.ins) begin
      if (at_upd) begin
        valid_d = 1'b1;
        node_d  = upd_i.node;
      end else if (above_upd) begin
        valid_d = left_i.valid;
        node_d  = left_i.node;
      end
    end else if (upd_i.del) begin
      if (at_upd || above_upd) begin
        valid_d = right_i.valid;
        node_d  = right_i.node;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
  end

  assign tok_o  = tok_q;
  assign slot_o = '{valid: valid_q, node: node_q};

endmodule

### bench/linked_list_queue_manager_test.sv
// Testbench for the linked-list queue manager: directed and random request traffic.
`timescale 1ns / 1ps

module linked_list_queue_manager_test;

  localparam int unsigned RANDOM_REQS  = 900;
  localparam int unsigned BLOCK_REQS   = 60;      // requests per fill-level block
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;      // idle time after the last response
  localparam int unsigned HOLD_AFTER   = 300;     // responses seen before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 500;

  typedef struct packed {
    llqm_pkg::req_e              kind;
    logic [llqm_pkg::NODE_W-1:0] node;
    logic [llqm_pkg::POS_W-1:0]  pos;
  } request_t;

  typedef struct packed {
    logic                        ok;
    logic [llqm_pkg::NODE_W-1:0] node;
    logic [llqm_pkg::POS_W-1:0]  index;
    logic [llqm_pkg::LEN_W-1:0]  count;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  llqm_req_if req_if ();
  llqm_rsp_if rsp_if ();

  linked_list_queue_manager #(
    .NODES (16)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tracking model of the queue. The list is circular: last_node is the tail,
  // chain[last_node] is the front, chain[n] is the successor of a queued n.
  // With 16 nodes every 4-bit id lies inside the pool.
  // ---------------------------------------------------------------------------
  logic [llqm_pkg::NODE_W-1:0] chain [llqm_pkg::ID_SPACE];
  bit                          member [llqm_pkg::ID_SPACE];
  logic [llqm_pkg::NODE_W-1:0] last_node;
  bit                          has_nodes;
  int unsigned                 queue_len;

  request_t    request_q [$];   // requests still to be offered
  answer_t     answer_q [$];    // predicted responses, oldest first
  int unsigned fault_cnt;
  int unsigned rsp_seen;

  // Insert a free node at the front.
  function automatic void link_front(input logic [llqm_pkg::NODE_W-1:0] n);
    if (has_nodes) begin
      chain[n]         = chain[last_node];
      chain[last_node] = n;
    end else begin
      last_node = n;
      chain[n]  = n;
      has_nodes = 1'b1;
    end
    member[n] = 1'b1;
    queue_len++;
  endfunction

  // Unlink the successor of a queued node and return it; move the tail back
  // when the tail itself goes, and empty the list when it was the only node.
  function automatic logic [llqm_pkg::NODE_W-1:0] unlink_next(
    input logic [llqm_pkg::NODE_W-1:0] prev);
    logic [llqm_pkg::NODE_W-1:0] gone;
    gone = chain[prev];
    if (gone == prev) begin
      has_nodes = 1'b0;
      last_node = '0;
    end else begin
      chain[prev] = chain[gone];
      if (gone == last_node) last_node = prev;
    end
    member[gone] = 1'b0;
    chain[gone]  = '0;
    if (queue_len > 0) queue_len--;
    return gone;
  endfunction

  // Node reached after a number of links, starting at the tail.
  function automatic logic [llqm_pkg::NODE_W-1:0] walk_from_tail(
    input logic [llqm_pkg::POS_W-1:0] steps);
    logic [llqm_pkg::NODE_W-1:0] p;
    p = last_node;
    for (int unsigned k = 0; k < steps; k++) p = chain[p];
    return p;
  endfunction

  // Predecessor of a queued node, and the node's position from the front.
  function automatic logic [llqm_pkg::NODE_W-1:0] pred_of(
    input logic [llqm_pkg::NODE_W-1:0] n, output logic [llqm_pkg::POS_W-1:0] at);
    logic [llqm_pkg::NODE_W-1:0] p;
    int unsigned                 i;
    p = last_node;
    i = 0;
    while (chain[p] != n && i < queue_len) begin
      p = chain[p];
      i++;
    end
    at = llqm_pkg::POS_W'(i);
    return p;
  endfunction

  // Apply one accepted request to the model and return the response it owes.
  function automatic answer_t predict_answer(input request_t r);
    answer_t                    a;
    logic [llqm_pkg::POS_W-1:0] at;
    a = '0;
    case (r.kind)
      llqm_pkg::REQ_PUSH_FRONT, llqm_pkg::REQ_PUSH_BACK: begin
        // A node already queued is refused and nothing moves.
        if (!member[r.node]) begin
          link_front(r.node);
          if (r.kind == llqm_pkg::REQ_PUSH_BACK) last_node = r.node;
          a.ok = 1'b1;
        end
      end
      llqm_pkg::REQ_POP: begin
        if (has_nodes) begin
          a.node = unlink_next(last_node);
          a.ok   = 1'b1;
        end
      end
      llqm_pkg::REQ_GET_AT: begin
        if (has_nodes && r.pos < queue_len) begin
          a.node = chain[walk_from_tail(r.pos)];
          a.ok   = 1'b1;
        end
      end
      llqm_pkg::REQ_REMOVE_AT: begin
        if (has_nodes && r.pos < queue_len) begin
          a.node = unlink_next(walk_from_tail(r.pos));
          a.ok   = 1'b1;
        end
      end
      llqm_pkg::REQ_REMOVE_NODE: begin
        if (has_nodes && member[r.node]) begin
          void'(unlink_next(pred_of(r.node, at)));
          a.ok = 1'b1;
        end
      end
      llqm_pkg::REQ_INDEX_OF: begin
        if (has_nodes && member[r.node]) begin
          void'(pred_of(r.node, at));
          a.index = at;
          a.ok    = 1'b1;
        end
      end
      default: begin
        // Nothing follows the tail, so next_of on it misses.
        if (has_nodes && member[r.node] && r.node != last_node) begin
          a.node = chain[r.node];
          a.ok   = 1'b1;
        end
      end
    endcase
    a.count = llqm_pkg::LEN_W'(queue_len);
    return a;
  endfunction

  // Random request; push_pct sets how hard the mix drives toward a full list.
  // Half the positions land near the front so that short lists get hits too.
  function automatic request_t random_request(input int unsigned push_pct);
    request_t r;
    r.node = llqm_pkg::NODE_W'($urandom_range(0, llqm_pkg::ID_SPACE - 1));
    r.pos  = ($urandom_range(0, 1) != 0) ? llqm_pkg::POS_W'($urandom_range(0, 3))
                                         : llqm_pkg::POS_W'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < push_pct)
      r.kind = ($urandom_range(0, 1) != 0) ? llqm_pkg::REQ_PUSH_BACK
                                           : llqm_pkg::REQ_PUSH_FRONT;
    else
      r.kind = llqm_pkg::req_e'($urandom_range(llqm_pkg::REQ_POP, llqm_pkg::REQ_NEXT_OF));
    return r;
  endfunction

  // Gap length for either side: mostly short, a few long, and now and then a
  // calm stretch with no gaps at all.
  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge only. Hold a request
  // until the rising edge that takes it, then idle or offer the next one.
  // ---------------------------------------------------------------------------
  int unsigned req_wait;
  int unsigned req_calm;
  bit          req_fire;

  always @(negedge clk_i) begin : drive_req
    request_t nxt;
    if (rst_ni && !(req_if.valid && !req_fire)) begin
      if (req_wait > 0) begin
        req_wait--;
        req_if.valid <= 1'b0;
      end else if (request_q.size() != 0) begin
        nxt = request_q.pop_front();
        req_if.valid    <= 1'b1;
        req_if.req_type <= nxt.kind;
        req_if.node_id  <= nxt.node;
        req_if.position <= nxt.pos;
        req_wait = pick_gap(req_calm);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Record each request taken at the rising edge and predict its response.
  always @(posedge clk_i) begin : watch_req
    req_fire = req_if.valid && req_if.ready;
    if (rst_ni && req_fire)
      answer_q.push_back(predict_answer('{kind: req_if.req_type, node: req_if.node_id,
                                          pos: req_if.position}));
  end

  // ---------------------------------------------------------------------------
  // Response side: random ready gaps, plus one long hold-off once traffic is
  // flowing so that the output register and the request input both back up.
  // ---------------------------------------------------------------------------
  int unsigned rsp_wait;
  int unsigned rsp_calm;
  int unsigned hold_left;
  bit          held_once;

  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (!held_once && rsp_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
        rsp_wait--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        rsp_wait = pick_gap(rsp_calm);
      end
    end
  end

  // Compare every accepted response, field by field, with the oldest prediction.
  always @(posedge clk_i) begin : check_rsp
    answer_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      rsp_seen++;
      if (answer_q.size() == 0) begin
        $error("response with no request outstanding");
        fault_cnt++;
      end else begin
        want = answer_q.pop_front();
        if (rsp_if.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, rsp_if.ok);
          fault_cnt++;
        end
        if (rsp_if.node_out !== want.node) begin
          $error("node_out: expected %0d, got %0d", want.node, rsp_if.node_out);
          fault_cnt++;
        end
        if (rsp_if.index_out !== want.index) begin
          $error("index_out: expected %0d, got %0d", want.index, rsp_if.index_out);
          fault_cnt++;
        end
        if (rsp_if.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp_if.count);
          fault_cnt++;
        end
      end
    end
  end

  // Abort a run that hangs.
  int unsigned cycle_cnt;

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** linked_list_queue_manager: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the request list, reset, drain, report.
  // ---------------------------------------------------------------------------
  initial begin : run
    int unsigned push_pct;

    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = llqm_pkg::REQ_POP;
    req_if.node_id  = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;

    for (int unsigned n = 0; n < llqm_pkg::ID_SPACE; n++) begin
      chain[n]  = '0;
      member[n] = 1'b0;
    end
    last_node = '0;
    has_nodes = 1'b0;
    queue_len = 0;

    // Directed part: misses on an empty list, extreme ids, duplicate pushes,
    // next_of on the tail, positions past the end, removal of a middle node,
    // of the tail and of the only node.
    request_q.push_back('{llqm_pkg::REQ_POP,         4'd0,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_GET_AT,      4'd0,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_INDEX_OF,    4'd5,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_NEXT_OF,     4'd3,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_PUSH_FRONT,  4'd0,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_PUSH_BACK,   4'd15, 4'd0});
    request_q.push_back('{llqm_pkg::REQ_PUSH_FRONT,  4'd15, 4'd0});
    request_q.push_back('{llqm_pkg::REQ_PUSH_BACK,   4'd0,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_NEXT_OF,     4'd15, 4'd0});
    request_q.push_back('{llqm_pkg::REQ_NEXT_OF,     4'd0,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_GET_AT,      4'd0,  4'd1});
    request_q.push_back('{llqm_pkg::REQ_GET_AT,      4'd0,  4'd2});
    request_q.push_back('{llqm_pkg::REQ_GET_AT,      4'd0,  4'd15});
    request_q.push_back('{llqm_pkg::REQ_INDEX_OF,    4'd15, 4'd0});
    request_q.push_back('{llqm_pkg::REQ_PUSH_FRONT,  4'd7,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_REMOVE_NODE, 4'd0,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_REMOVE_AT,   4'd0,  4'd1});
    request_q.push_back('{llqm_pkg::REQ_REMOVE_AT,   4'd0,  4'd15});
    request_q.push_back('{llqm_pkg::REQ_REMOVE_NODE, 4'd7,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_REMOVE_NODE, 4'd7,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_PUSH_BACK,   4'd3,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_REMOVE_AT,   4'd0,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_PUSH_FRONT,  4'd9,  4'd0});
    request_q.push_back('{llqm_pkg::REQ_POP,         4'd0,  4'd0});

    // Random part: each block picks a push share, so the list swings between
    // empty and full and every position gets exercised.
    for (int unsigned b = 0; b < RANDOM_REQS / BLOCK_REQS; b++) begin
      case ($urandom_range(0, 3))
        0:       push_pct = 15;
        1:       push_pct = 40;
        2:       push_pct = 65;
        default: push_pct = 90;
      endcase
      for (int unsigned k = 0; k < BLOCK_REQS; k++)
        request_q.push_back(random_request(push_pct));
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Wait for the last request to go in and its response to come back, then
    // let the cell row settle in case something stray pops out.
    while (request_q.size() != 0 || req_if.valid) @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fault_cnt == 0) begin
      $display("** linked_list_queue_manager: PASSED **");
    end else begin
      $display("** linked_list_queue_manager: FAILED **");
    end
    $finish;
  end

endmodule
